// File: sv/frame_ring_queue_keep_last_core_macros.svh
// Assertion helpers for the ring queue core.
// All checks sample on the rising edge of clk and are off while arst_n is low.
`ifndef FRAME_RING_QUEUE_KEEP_LAST_CORE_MACROS_SVH
`define FRAME_RING_QUEUE_KEEP_LAST_CORE_MACROS_SVH

// Same-cycle implication
`define FRQKL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FRQKL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/frqkl_pkg.sv
`timescale 1ns / 1ps
package frqkl_pkg;

	localparam int REQ_W    = 3;
	localparam int FRAME_W  = 32;
	localparam int STAT_W   = 2;
	localparam int HC_W     = 5;   // held count, remaining and queue limit width
	localparam int CFG_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int QUEUE_LIMIT_RST = 16;
	localparam logic KEEP_LAST_RST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LAST   = 1'b1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH      = 3'd0,
		REQ_ADVANCE   = 3'd1,
		REQ_PEEK_CUR  = 3'd2,
		REQ_PEEK_NEXT = 3'd3,
		REQ_PEEK_LAST = 3'd4
	} frqkl_req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ABORT = 2'd3
	} frqkl_status_t;

endpackage

// File: sv/frame_ring_queue_keep_last_core.sv
`timescale 1ns / 1ps
// Channel   | Signals                                        | Transfer
// ----------+------------------------------------------------+--------------------------
// request   | start, busy, req_type, frame_word, abort_flag  | start && !busy
// result    | done, status, read_word, remaining             | done (single cycle)
// config    | cfg_we, cfg_index, cfg_data                    | cfg_we
//
// One request per cycle while busy is low; each result is on done in the cycle after its request
// transfer, aligned with the registered read of the entry store.
// A write to queue_limit starts a position reduction: busy stays high until both
// positions are below the new limit (one compare-subtract of the limit per cycle), and
// no request transfers meanwhile.
// Reset (arst_n low) clears pointers, count, shown flag and registers; the store keeps
// no reset. The receiver cannot stall results, so none is ever held back.
module frame_ring_queue_keep_last_core import frqkl_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request
	input  logic                 start,
	output logic                 busy,
	input  logic [REQ_W-1:0]     req_type,
	input  logic [FRAME_W-1:0]   frame_word,
	input  logic                 abort_flag,
	// result
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [FRAME_W-1:0]   read_word,
	output logic [HC_W-1:0]      remaining,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

`include "frame_ring_queue_keep_last_core_macros.svh"

	// Largest usable limit: the 5-bit register caps it at 31.
	localparam int MAX_LIM = (DEPTH < 31) ? DEPTH : 31;
	localparam int PW      = $clog2(MAX_LIM);       // ring position
	localparam int LW      = $clog2(MAX_LIM + 1);   // effective limit
	localparam int SW      = LW + 1;                // position plus offset
	localparam int AW      = $clog2(DEPTH);         // store address
	localparam int LIM_RST = (QUEUE_LIMIT_RST < MAX_LIM) ? QUEUE_LIMIT_RST : MAX_LIM;

	// (pos + add) mod lim, with pos already below lim and add at most two
	function automatic logic [PW-1:0] slot_f(input logic [PW-1:0] pos,
		input logic [1:0] add, input logic [LW-1:0] lim);
		logic [SW-1:0] s;
		s = SW'(pos) + SW'(add);
		if (s >= SW'(lim)) begin
			s = s - SW'(lim);
		end
		if (s >= SW'(lim)) begin
			s = s - SW'(lim);
		end
		return PW'(s);
	endfunction

	// Architectural state
	logic [LW-1:0]   lim_q;        // effective limit, clamped on write
	logic            keep_q;
	logic [HC_W-1:0] held_q;
	logic            shown_q;
	logic [PW-1:0]   rp_q;         // positions reduced by the current limit
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_raw_q;     // positions as last moved by a request
	logic [PW-1:0]   wp_raw_q;

	// Result pipeline
	logic                 done_s1;
	frqkl_status_t        status_s1;
	logic [HC_W-1:0]      remaining_s1;
	logic                 peek_ok_s1;

	// Request decode
	logic            accept;
	logic            lim_wr;
	logic [LW-1:0]   lim_new;
	frqkl_status_t   status_d;
	logic [HC_W-1:0] held_d;
	logic            shown_d;
	logic [PW-1:0]   rp_d;
	logic [PW-1:0]   wp_d;
	logic            rp_mv;
	logic            mem_we;
	logic            mem_re;
	logic [PW-1:0]   rd_pos;
	logic [HC_W-1:0] avail;
	logic [HC_W-1:0] lim_ext;
	logic [WORD_BITS-1:0] mem_rdata;

	logic          norm_busy;
	logic          norm_fin;
	logic [PW-1:0] norm_rp;
	logic [PW-1:0] norm_wp;

	assign accept  = start && !busy;
	assign lim_wr  = cfg_we && (cfg_index == CFG_QUEUE_LIMIT);
	assign avail   = held_q - HC_W'(shown_q);
	assign lim_ext = HC_W'(lim_q);

	// Clamp to the built depth; zero behaves as one.
	always_comb begin
		if (cfg_data == '0) begin
			lim_new = LW'(1);
		end else if (cfg_data > CFG_W'(MAX_LIM)) begin
			lim_new = LW'(MAX_LIM);
		end else begin
			lim_new = LW'(cfg_data);
		end
	end

	always_comb begin
		status_d = ST_OK;
		held_d   = held_q;
		shown_d  = shown_q;
		rp_d     = rp_q;
		wp_d     = wp_q;
		rp_mv    = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rd_pos   = rp_q;
		case (frqkl_req_t'(req_type))
			REQ_PUSH: begin
				if (abort_flag) begin
					status_d = ST_ABORT;
				end else if (held_q >= lim_ext) begin
					status_d = ST_FULL;
				end else begin
					mem_we = 1'b1;
					wp_d   = slot_f(wp_q, 2'd1, lim_q);
					held_d = held_q + HC_W'(1);
				end
			end
			REQ_ADVANCE: begin
				// abort is not looked at here
				if (held_q <= HC_W'(shown_q)) begin
					status_d = ST_EMPTY;
				end else if (keep_q && !shown_q) begin
					shown_d = 1'b1;   // first advance only marks the entry as shown
				end else begin
					rp_mv  = 1'b1;
					rp_d   = slot_f(rp_q, 2'd1, lim_q);
					held_d = held_q - HC_W'(1);
				end
			end
			REQ_PEEK_CUR: begin
				if (abort_flag) begin
					status_d = ST_ABORT;
				end else if (avail < HC_W'(1)) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					rd_pos = slot_f(rp_q, {1'b0, shown_q}, lim_q);
				end
			end
			REQ_PEEK_NEXT: begin
				if (avail < HC_W'(2)) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					rd_pos = slot_f(rp_q, {1'b0, shown_q} + 2'd1, lim_q);
				end
			end
			REQ_PEEK_LAST: begin
				if (held_q < HC_W'(1)) begin
					status_d = ST_EMPTY;
				end else begin
					mem_re = 1'b1;
					rd_pos = rp_q;
				end
			end
			default: begin
				// unused codes: no effect, status ok
			end
		endcase
	end

	frqkl_store #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_store (
		.clk   (clk),
		.we    (accept && mem_we),
		.waddr (AW'(wp_q)),
		.wdata (WORD_BITS'(frame_word)),
		.re    (accept && mem_re),
		.raddr (AW'(rd_pos)),
		.rdata (mem_rdata)
	);

	// Re-reduces both positions after a limit change.
	frqkl_norm #(
		.PW (PW),
		.LW (LW)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (lim_wr),
		.raw_rp (rp_raw_q),
		.raw_wp (wp_raw_q),
		.lim    (lim_q),
		.busy   (norm_busy),
		.fin    (norm_fin),
		.rp_n   (norm_rp),
		.wp_n   (norm_wp)
	);

	assign busy = norm_busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= LW'(LIM_RST);
			keep_q <= KEEP_LAST_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_QUEUE_LIMIT) begin
				lim_q <= lim_new;
			end
			if (cfg_index == CFG_KEEP_LAST) begin
				keep_q <= cfg_data[0];
			end
		end
	end

	// Queue state: updated on the request transfer (positions also when a reduction ends),
	// so the next request sees it straight away and the store write lands before its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			shown_q  <= 1'b0;
			rp_q     <= '0;
			wp_q     <= '0;
			rp_raw_q <= '0;
			wp_raw_q <= '0;
		end else if (norm_fin) begin
			rp_q <= norm_rp;
			wp_q <= norm_wp;
		end else if (accept) begin
			held_q  <= held_d;
			shown_q <= shown_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			// raw copies change only when the position itself moves
			if (rp_mv) begin
				rp_raw_q <= rp_d;
			end
			if (mem_we) begin
				wp_raw_q <= wp_d;
			end
		end
	end

	// Result stage, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1    <= 1'b0;
			peek_ok_s1 <= 1'b0;
		end else begin
			done_s1    <= accept;
			peek_ok_s1 <= accept && mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_d;
			remaining_s1 <= held_d - HC_W'(shown_d);
		end
	end

	assign done      = done_s1;
	assign status    = status_s1;
	assign remaining = remaining_s1;
	assign read_word = peek_ok_s1 ? FRAME_W'(mem_rdata) : '0;

	// Checks
	`FRQKL_ASSERT_NXT(a_done_follows, accept, done, "result strobe missing after transfer")
	`FRQKL_ASSERT_IMP(a_shown_held, 1'b1, held_q >= HC_W'(shown_q), "shown flag without entry")
	`FRQKL_ASSERT_IMP(a_pos_reduced, !busy, (LW'(rp_q) < lim_q) && (LW'(wp_q) < lim_q), "pos")
	`FRQKL_ASSERT_IMP(a_word_ok, done && (status != ST_OK), read_word == '0, "word on failure")

endmodule

// File: sv/frqkl_store.sv
`timescale 1ns / 1ps
module frqkl_store import frqkl_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rd_s1 <= mem[raddr];
		end
	end

	assign rdata = rd_s1;

endmodule

// File: sv/frqkl_norm.sv
`timescale 1ns / 1ps
module frqkl_norm import frqkl_pkg::*; #(
	parameter int PW = 4,
	parameter int LW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [PW-1:0] raw_rp,
	input  logic [PW-1:0] raw_wp,
	input  logic [LW-1:0] lim,
	output logic          busy,
	output logic          fin,
	output logic [PW-1:0] rp_n,
	output logic [PW-1:0] wp_n
);

	logic          active_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_q;
	logic          rp_ge;
	logic          wp_ge;

	// one compare-subtract per cycle on both positions
	assign rp_ge = LW'(rp_q) >= lim;
	assign wp_ge = LW'(wp_q) >= lim;
	assign fin   = active_q && !rp_ge && !wp_ge;
	assign busy  = active_q;
	assign rp_n  = rp_q;
	assign wp_n  = wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (fin) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rp_q <= raw_rp;
			wp_q <= raw_wp;
		end else if (active_q) begin
			if (rp_ge) begin
				rp_q <= rp_q - PW'(lim);
			end
			if (wp_ge) begin
				wp_q <= wp_q - PW'(lim);
			end
		end
	end

endmodule

// File: verif/tb_frame_ring_queue_keep_last_core.sv
`timescale 1ns / 1ps
// Ring queue with keep-last: a short drill of edge cases, then constrained-by-hand random
// traffic across several limit / keep-last settings. Every result is checked against a
// hand-typed answer or a cycle-free shadow of the queue updated as each request is driven.
module tb_frame_ring_queue_keep_last_core;
	import frqkl_pkg::*;

	// request codes beyond the defined set; the core must answer them with a plain OK
	localparam logic [REQ_W-1:0] REQ_RSVD_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_RSVD_HI = 3'd7;

	localparam int PHASES    = 8;
	localparam int PER_PHASE = 228;
	localparam int RAND_ALL  = PHASES * PER_PHASE;
	// phase 0 runs on the reset settings; the rest rewrite both registers
	localparam int PHASE_LIM  [PHASES] = '{16, 31, 1, 0, 5, 16, 2, 9};
	localparam int PHASE_KEEP [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};

	typedef struct {
		frqkl_status_t    st;
		logic [FRAME_W-1:0] word;
		logic [HC_W-1:0]  rem;
	} queue_result_t;

	// one drill row: either a register write or a request, optionally with a hand-typed answer
	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		logic [REQ_W-1:0]     req;
		logic [FRAME_W-1:0]   word;
		bit                   abort_req;
		bit                   typed;
		queue_result_t        want;
	} drill_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [REQ_W-1:0]     req_type = '0;
	logic [FRAME_W-1:0]   frame_word = '0;
	logic                 abort_flag = 1'b0;
	logic                 done;
	logic [STAT_W-1:0]    status;
	logic [FRAME_W-1:0]   read_word;
	logic [HC_W-1:0]      remaining;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// shadow of the queue
	logic [FRAME_W-1:0] fifo_words [DEPTH_DEF];
	bit                 word_valid [DEPTH_DEF];
	int unsigned        put_idx = 0;
	int unsigned        take_idx = 0;
	int unsigned        occupancy = 0;
	int unsigned        shown_held = 0;
	logic [CFG_W-1:0]   limit_shadow = CFG_W'(QUEUE_LIMIT_RST);
	bit                 keep_shadow = KEEP_LAST_RST;

	queue_result_t expected_q [$];
	drill_row_t    drill_q [$];
	queue_result_t blank_res = '{ST_OK, '0, '0};
	int unsigned   fault_cnt = 0;
	int unsigned   rand_count = 0;

	frame_ring_queue_keep_last_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.frame_word (frame_word),
		.abort_flag (abort_flag),
		.done       (done),
		.status     (status),
		.read_word  (read_word),
		.remaining  (remaining),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// entries in use: limit clipped to the built depth, zero behaves as one
	function automatic int unsigned ring_span();
		int unsigned s;
		s = limit_shadow;
		if (s > DEPTH_DEF)
			s = DEPTH_DEF;
		if (s == 0)
			s = 1;
		return s;
	endfunction

	function automatic int unsigned ring_wrap(input int unsigned pos, input int unsigned add);
		return (pos + add) % ring_span();
	endfunction

	// slot a peek would read; peek last always looks at the oldest held entry
	function automatic int unsigned peek_index(input logic [REQ_W-1:0] req);
		case (req)
			REQ_PEEK_CUR:  return ring_wrap(take_idx, shown_held);
			REQ_PEEK_NEXT: return ring_wrap(take_idx, shown_held + 1);
			default:       return ring_wrap(take_idx, 0);
		endcase
	endfunction

	function automatic queue_result_t predict_req(input logic [REQ_W-1:0] req,
		input logic [FRAME_W-1:0] word, input bit abort_req);
		queue_result_t res;
		int unsigned   w;
		int unsigned   avail;
		res.st   = ST_OK;
		res.word = '0;
		avail    = occupancy - shown_held;
		case (req)
			REQ_PUSH: begin
				if (abort_req)
					res.st = ST_ABORT;
				else if (occupancy >= ring_span())
					res.st = ST_FULL;
				else begin
					w = ring_wrap(put_idx, 0);
					fifo_words[w] = word;
					word_valid[w] = 1'b1;
					put_idx = ring_wrap(w, 1);
					occupancy++;
				end
			end
			REQ_ADVANCE: begin
				// abort is not looked at; the first keep-last advance only marks as shown
				if (occupancy <= shown_held)
					res.st = ST_EMPTY;
				else if (keep_shadow && shown_held == 0)
					shown_held = 1;
				else begin
					take_idx = ring_wrap(take_idx, 1);
					occupancy--;
				end
			end
			REQ_PEEK_CUR: begin
				if (abort_req)
					res.st = ST_ABORT;
				else if (avail < 1)
					res.st = ST_EMPTY;
				else
					res.word = fifo_words[peek_index(req)];
			end
			REQ_PEEK_NEXT: begin
				if (avail < 2)
					res.st = ST_EMPTY;
				else
					res.word = fifo_words[peek_index(req)];
			end
			REQ_PEEK_LAST: begin
				if (occupancy < 1)
					res.st = ST_EMPTY;
				else
					res.word = fifo_words[peek_index(req)];
			end
			default: ;
		endcase
		res.rem = HC_W'(occupancy - shown_held);
		return res;
	endfunction

	function automatic void drill(input logic [REQ_W-1:0] req, input logic [FRAME_W-1:0] word,
		input bit abort_req, input bit typed, input frqkl_status_t st, input logic [HC_W-1:0] rem);
		drill_row_t row;
		row.is_reg    = 1'b0;
		row.reg_idx   = '0;
		row.reg_val   = '0;
		row.req       = req;
		row.word      = word;
		row.abort_req = abort_req;
		row.typed     = typed;
		row.want.st   = st;
		row.want.word = '0;
		row.want.rem  = rem;
		drill_q.push_back(row);
	endfunction

	function automatic void drill_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drill_row_t row;
		row.is_reg    = 1'b1;
		row.reg_idx   = idx;
		row.reg_val   = val;
		row.req       = '0;
		row.word      = '0;
		row.abort_req = 1'b0;
		row.typed     = 1'b0;
		row.want.st   = ST_OK;
		row.want.word = '0;
		row.want.rem  = '0;
		drill_q.push_back(row);
	endfunction

	task automatic log_mismatch(input string what, input queue_result_t want);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%0t: %s: want st=%0d word=%h rem=%0d, got st=%0d word=%h rem=%0d",
				$time, what, want.st, want.word, want.rem, status, read_word, remaining);
	endtask

	// Results are sampled mid-cycle, well clear of the edge at which the core updates them.
	always @(negedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0)
				log_mismatch("result with nothing outstanding", blank_res);
			else begin
				want = expected_q.pop_front();
				if (status !== want.st || read_word !== want.word || remaining !== want.rem)
					log_mismatch("result mismatch", want);
			end
		end
	end

	// Called at a rising edge; returns at the edge on which the transfer took place.
	// The shadow is updated on drive: only one request is ever in flight at the port.
	task automatic issue_req(input logic [REQ_W-1:0] req, input logic [FRAME_W-1:0] word,
		input bit abort_req, input int unsigned idle_pct, input bit typed,
		input queue_result_t typed_res);
		queue_result_t res;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= req;
		frame_word <= word;
		abort_flag <= abort_req;
		res = predict_req(req, word, abort_req);
		expected_q.push_back(typed ? typed_res : res);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// stop sending and let every outstanding result come back
	task automatic settle();
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// only while idle; a limit write kicks off the position reduction, so wait out busy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_QUEUE_LIMIT)
			limit_shadow = val;
		else
			keep_shadow = val[0];
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_random(input int unsigned n);
		logic [REQ_W-1:0]   req;
		logic [FRAME_W-1:0] word;
		bit                 abort_req;
		int unsigned        pick;
		int unsigned        push_pct;
		int unsigned        idle_pct;
		for (int unsigned i = 0; i < n; i++) begin
			// alternate fill-heavy and drain-heavy stretches so full and empty both get hit
			push_pct = ((rand_count / 24) % 2 == 0) ? 60 : 20;
			idle_pct = (rand_count < RAND_ALL / 3) ? 8 : (rand_count < 2 * RAND_ALL / 3) ? 81 : 0;
			if ($urandom_range(99) < push_pct)
				req = REQ_PUSH;
			else begin
				pick = $urandom_range(99);
				if (pick < 35)
					req = REQ_ADVANCE;
				else if (pick < 55)
					req = REQ_PEEK_CUR;
				else if (pick < 72)
					req = REQ_PEEK_NEXT;
				else if (pick < 92)
					req = REQ_PEEK_LAST;
				else
					req = REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
			end
			// never read a slot the core has not yet written
			if ((req == REQ_PEEK_CUR || req == REQ_PEEK_NEXT || req == REQ_PEEK_LAST)
				&& !word_valid[peek_index(req)])
				req = REQ_PUSH;
			abort_req = ($urandom_range(7) == 0);
			case ($urandom_range(9))
				0:       word = '0;
				1:       word = '1;
				default: word = $urandom;
			endcase
			issue_req(req, word, abort_req, idle_pct, 1'b0, blank_res);
			rand_count++;
		end
	endtask

	initial begin
		drill_row_t row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: every read is refused, aborts win, reserved codes are no-ops
		drill(REQ_PEEK_CUR,  '0, 1'b0, 1'b1, ST_EMPTY, 5'd0);
		drill(REQ_PEEK_NEXT, '0, 1'b0, 1'b1, ST_EMPTY, 5'd0);
		drill(REQ_PEEK_LAST, '0, 1'b0, 1'b1, ST_EMPTY, 5'd0);
		drill(REQ_ADVANCE,   '0, 1'b0, 1'b1, ST_EMPTY, 5'd0);
		drill(REQ_PUSH,      '1, 1'b1, 1'b1, ST_ABORT, 5'd0);
		drill(REQ_PEEK_CUR,  '0, 1'b1, 1'b1, ST_ABORT, 5'd0);
		drill(REQ_RSVD_HI,   '1, 1'b1, 1'b1, ST_OK,    5'd0);
		// three pushes with extreme words
		drill(REQ_PUSH, 32'h0000_0000, 1'b0, 1'b1, ST_OK, 5'd1);
		drill(REQ_PUSH, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_OK, 5'd2);
		drill(REQ_PUSH, 32'hA5A5_5A5A, 1'b0, 1'b1, ST_OK, 5'd3);
		drill(REQ_PEEK_CUR,  '0, 1'b0, 1'b0, ST_OK, 5'd0);
		// abort only matters to push and peek current
		drill(REQ_PEEK_NEXT, '0, 1'b1, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_LAST, '0, 1'b1, 1'b0, ST_OK, 5'd0);
		// plain queue: advance frees straight away
		drill_reg(CFG_KEEP_LAST, 5'd0);
		drill(REQ_ADVANCE,   '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_CUR,  '0, 1'b0, 1'b0, ST_OK, 5'd0);
		// keep-last: first advance only marks the head as shown
		drill_reg(CFG_KEEP_LAST, 5'd1);
		drill(REQ_ADVANCE,   '0, 1'b1, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_CUR,  '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_NEXT, '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_LAST, '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_ADVANCE,   '0, 1'b0, 1'b0, ST_OK, 5'd0);
		// only the shown entry left: it can be seen last but never freed
		drill(REQ_ADVANCE,   '0, 1'b0, 1'b1, ST_EMPTY, 5'd0);
		drill(REQ_PEEK_CUR,  '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_PEEK_LAST, '0, 1'b0, 1'b0, ST_OK, 5'd0);
		drill(REQ_RSVD_LO,   '0, 1'b0, 1'b1, ST_OK, 5'd0);

		foreach (drill_q[i]) begin
			row = drill_q[i];
			if (row.is_reg) begin
				settle();
				write_reg(row.reg_idx, row.reg_val);
			end else
				issue_req(row.req, row.word, row.abort_req, 0, row.typed, row.want);
		end

		// random traffic; each new setting is applied once all outstanding results are back
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				write_reg(CFG_KEEP_LAST, CFG_W'(PHASE_KEEP[p]));
				write_reg(CFG_QUEUE_LIMIT, CFG_W'(PHASE_LIM[p]));
			end
			run_random(PER_PHASE);
		end

		settle();
		repeat (4) @(posedge clk);
		fault_cnt += expected_q.size();
		if (fault_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/frqkl_pkg.sv
sv/frqkl_store.sv
sv/frqkl_norm.sv
sv/frame_ring_queue_keep_last_core.sv
verif/tb_frame_ring_queue_keep_last_core.sv
